FILE: design/sha_pkg.sv
// Package with the state type, round constants and mixing functions of the hasher.
`default_nettype none

package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_DONE
  } state_e;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

FILE: design/sha256_hasher.sv
// A byte-serial SHA-256 hasher that computes one round per cycle.
// An item is taken while the input is not stalled; an item that completes a 64-byte block then stalls the
// input through 64 rounds in the shared round unit and one chaining update.
// An end mark pads one byte per cycle over at most two blocks, compresses each padded block in
// the shared round unit and, in the done state, loads the digest register once the output is free.
// Reset restores the initial hash values, clears the fill and length counters and drops the result.
`default_nettype none

module sha256_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  msg_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_w0_o,
  output logic [31:0]      digest_w1_o,
  output logic [31:0]      digest_w2_o,
  output logic [31:0]      digest_w3_o,
  output logic [31:0]      digest_w4_o,
  output logic [31:0]      digest_w5_o,
  output logic [31:0]      digest_w6_o,
  output logic [31:0]      digest_w7_o
);
  import sha_pkg::*;

  state_e        state_q, state_d;
  logic [511:0]  win_q, win_d;
  logic [31:0]   h_q [8];
  logic [31:0]   h_d [8];
  logic [31:0]   v_q [8];
  logic [31:0]   v_d [8];
  logic [31:0]   dig_q [8];
  logic [31:0]   dig_d [8];
  logic [5:0]    fill_q, fill_d;
  logic [5:0]    rnd_q, rnd_d;
  logic [60:0]   total_q, total_d;
  logic          pad_q, pad_d;
  logic          mark_q, mark_d;
  logic          lenok_q, lenok_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;

  logic          in_acc;
  logic          out_free;
  logic          wr_en;
  logic [7:0]    wr_byte;
  logic [7:0]    pad_byte;
  logic [63:0]   bit_len;
  logic [63:0]   len_shift;
  logic [31:0]   w_cur;
  logic [31:0]   w_new;
  logic [31:0]   t1;
  logic [31:0]   t2;
  logic [31:0]   ch;
  logic [31:0]   maj;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_present_i && fill_q == LAST_POS) begin
            state_d = ST_ROUND;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == LAST_POS) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == LAST_POS) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (last_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign bit_len   = {total_q, 3'b000};
  assign len_shift = bit_len >> {3'(~fill_q[2:0]), 3'b000};

  always_comb begin
    if (!mark_q) begin
      pad_byte = PAD_MARK;
    end else if (fill_q >= LEN_POS && lenok_q) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign w_cur = win_q[511:480];
  assign w_new = small_s1(win_q[63:32]) + win_q[223:192] + small_s0(win_q[479:448]) + w_cur;
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + big_s1(v_q[4]) + ch + ROUND_K[rnd_q] + w_cur;
  assign t2    = big_s0(v_q[0]) + maj;

  always_comb begin
    win_d       = win_q;
    h_d         = h_q;
    v_d         = v_q;
    dig_d       = dig_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    total_d     = total_q;
    pad_d       = pad_q;
    mark_d      = mark_q;
    lenok_d     = lenok_q;
    last_d      = last_q;
    out_valid_d = out_valid_q & out_stall_i;
    wr_en       = 1'b0;
    wr_byte     = pad_byte;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pad_d = end_of_message_i;
          if (byte_present_i) begin
            wr_en   = 1'b1;
            wr_byte = msg_byte_i;
            total_d = total_q + 61'd1;
          end
        end
      end
      ST_PAD: begin
        wr_en = 1'b1;
        if (!mark_q) begin
          mark_d  = 1'b1;
          lenok_d = (fill_q < LEN_POS);
        end
        if (fill_q == LAST_POS) begin
          last_d = mark_q & lenok_q;
        end
      end
      ST_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        win_d  = {win_q[479:0], w_new};
        rnd_d  = rnd_q + 6'd1;
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (pad_q && !last_q) begin
          lenok_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          dig_d       = h_q;
          out_valid_d = 1'b1;
          h_d         = INIT_H;
          total_d     = '0;
          pad_d       = 1'b0;
          mark_d      = 1'b0;
          lenok_d     = 1'b0;
          last_d      = 1'b0;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    if (wr_en) begin
      win_d  = {win_q[503:0], wr_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q == LAST_POS) begin
        v_d   = h_q;
        rnd_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= INIT_H;
      fill_q      <= '0;
      total_q     <= '0;
      pad_q       <= 1'b0;
      mark_q      <= 1'b0;
      lenok_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      pad_q       <= pad_d;
      mark_q      <= mark_d;
      lenok_q     <= lenok_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
    dig_q <= dig_d;
    rnd_q <= rnd_d;
  end

  assign out_valid_o = out_valid_q;
  assign digest_w0_o = dig_q[0];
  assign digest_w1_o = dig_q[1];
  assign digest_w2_o = dig_q[2];
  assign digest_w3_o = dig_q[3];
  assign digest_w4_o = dig_q[4];
  assign digest_w5_o = dig_q[5];
  assign digest_w6_o = dig_q[6];
  assign digest_w7_o = dig_q[7];

endmodule

`default_nettype wire

FILE: design/sha_chk.sv
// Port-level checker for the hasher and the bind that attaches it.
`default_nettype none

module sha_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        end_of_message_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] digest_w0_o,
  input wire logic [31:0] digest_w7_o
);

  // An item is held while the downstream side stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(digest_w0_o) && $stable(digest_w7_o))
    else $error("Result item changed while stalled.");

  // An end mark starts padding or rounds, so the input must stall next.
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_message_i |=> in_stall_o)
    else $error("Input taken during padding.");

  // A digest is only loaded by the busy sequencer.
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result item appeared while the hasher was idle.");

endmodule

bind sha256_hasher sha_chk u_sha_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .end_of_message_i (end_of_message_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .digest_w0_o      (digest_w0_o),
  .digest_w7_o      (digest_w7_o)
);

`default_nettype wire
